FILE: rtl/core/rwpt_pkg.sv
package rwpt_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 8;
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int MARGIN     = 20;
   localparam int MIN_SCALE  = (2 * ONE) / 100;
   localparam int NSTAGE     = 10;

   typedef enum logic [3:0] {
      CSR_BOX_X         = 4'd0,
      CSR_BOX_Y         = 4'd1,
      CSR_BOX_W         = 4'd2,
      CSR_BOX_H         = 4'd3,
      CSR_CORNER_RADIUS = 4'd4,
      CSR_WARP_FACTORS  = 4'd5,
      CSR_CORNER_TILT   = 4'd6,
      CSR_EYE_COLOR     = 4'd7
   } csr_index_type;

   // derived shape settings; the user keeps them static while pixels flow, the block does not enforce it
   typedef struct packed {
      logic [9:0]         w;
      logic [9:0]         h;
      logic [8:0]         r;
      logic [7:0]         tp;
      logic [7:0]         bp;
      logic [7:0]         tc;
      logic [7:0]         bc;
      logic signed [12:0] inner;
      logic signed [12:0] outer;
      logic               simple;
   } cfg_type;

   typedef struct packed {
      logic        m;
      logic        sok;
      logic        sen;
      logic [9:0]  sdx;
      logic [9:0]  sdy;
      logic        wok;
      logic        wen;
      logic [18:0] lx;
      logic [18:0] ly;
      logic [17:0] aw;
      logic [17:0] ah;
      logic [16:0] er;
   } geom_type;

   typedef struct packed {
      logic        ok;
      logic        en;
      logic [33:0] dxx;
      logic [33:0] dyy;
      logic [33:0] rr2;
   } sq_type;

   // signed q1.7 byte times 15 pixels, in q.8
   function automatic logic signed [12:0] tilt_q(input logic [7:0] b);
      logic signed [12:0] v;
      v = 13'(signed'(b));
      return v * 13'sd30;
   endfunction

endpackage

FILE: rtl/core/rwpt_div.sv
module rwpt_div import rwpt_pkg::*; (
   input  logic               clock,
   input  logic [1:0]         ld,
   input  logic signed [10:0] num_i,
   input  logic [9:0]         den,
   output logic [8:0]         q_o,
   output logic signed [10:0] num_o
);

   logic               zero_in, full_in;
   logic [9:0]         rem1_in, rem2_in;
   logic [3:0]         qh_in, ql_in;
   logic [10:0]        t1, t2;
   logic [8:0]         q_in;

   logic               zero_ff, full_ff;
   logic [9:0]         rem_ff;
   logic [3:0]         qh_ff;
   logic signed [10:0] num1_ff, num2_ff;
   logic [8:0]         q_ff;

   // first four quotient bits of num*256/den
   always_comb begin
      zero_in = (den == 10'd0) || num_i[10] || (num_i == 11'sd0);
      full_in = !zero_in && (num_i[9:0] >= den);
      rem1_in = num_i[9:0];
      qh_in   = 4'd0;
      t1      = 11'd0;
      for (int i = 0; i < 4; i++) begin
         t1 = {rem1_in, 1'b0};
         if (t1 >= {1'b0, den}) begin
            rem1_in = 10'(t1 - {1'b0, den});
            qh_in   = {qh_in[2:0], 1'b1};
         end else begin
            rem1_in = t1[9:0];
            qh_in   = {qh_in[2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         zero_ff <= zero_in;
         full_ff <= full_in;
         rem_ff  <= rem1_in;
         qh_ff   <= qh_in;
         num1_ff <= num_i;
      end
   end

   always_comb begin
      rem2_in = rem_ff;
      ql_in   = 4'd0;
      t2      = 11'd0;
      for (int i = 0; i < 4; i++) begin
         t2 = {rem2_in, 1'b0};
         if (t2 >= {1'b0, den}) begin
            rem2_in = 10'(t2 - {1'b0, den});
            ql_in   = {ql_in[2:0], 1'b1};
         end else begin
            rem2_in = t2[9:0];
            ql_in   = {ql_in[2:0], 1'b0};
         end
      end
      if (zero_ff)
         q_in = 9'd0;
      else if (full_ff)
         q_in = 9'(ONE);
      else
         q_in = {1'b0, qh_ff, ql_in};
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         q_ff    <= q_in;
         num2_ff <= num1_ff;
      end
   end

   assign q_o   = q_ff;
   assign num_o = num2_ff;

endmodule

FILE: rtl/core/rwpt_geom.sv
module rwpt_geom import rwpt_pkg::*; (
   input  logic               clock,
   input  logic [3:0]         ld,
   input  cfg_type            cfg,
   input  logic [8:0]         nx,
   input  logic [8:0]         ny,
   input  logic signed [10:0] rx,
   input  logic signed [10:0] ry,
   output geom_type           g_o
);

   // stage a: margin, products of the normalised position
   logic signed [12:0] rx13, ry13, wl, hl;
   logic [9:0]         omy, nx2, pf;
   logic               lo, m_in;
   logic signed [21:0] rnum_in;
   logic [15:0]        cprod_in;
   logic [8:0]         dist_in;
   logic [16:0]        pprod_in;

   logic               m3_ff;
   logic signed [21:0] rnum_ff;
   logic [15:0]        cprod_ff;
   logic [8:0]         dist_ff;
   logic [16:0]        pprod_ff;
   logic signed [10:0] rx3_ff, ry3_ff;

   always_comb begin
      rx13 = 13'(rx);
      ry13 = 13'(ry);
      wl   = signed'({3'b0, cfg.w}) + 13'(MARGIN);
      hl   = signed'({3'b0, cfg.h}) + 13'(MARGIN);
      m_in = (rx13 >= -13'(MARGIN)) && (rx13 < wl) && (ry13 >= -13'(MARGIN)) && (ry13 < hl);
      omy  = 10'(ONE) - {1'b0, ny};
      rnum_in = 22'(cfg.inner) * 22'(signed'({1'b0, omy}))
              + 22'(cfg.outer) * 22'(signed'({1'b0, ny}));
      cprod_in = 16'(ny) * 16'(omy);
      lo   = nx < 9'(ONE / 2);
      dist_in = lo ? 9'((9'(ONE / 2) - nx) << 1) : 9'((nx - 9'(ONE / 2)) << 1);
      nx2  = {nx, 1'b0};
      pf   = lo ? (10'(ONE) - nx2) : (nx2 - 10'(ONE));
      pprod_in = 17'(lo ? cfg.tp : cfg.bp) * 17'(pf);
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         m3_ff    <= m_in;
         rnum_ff  <= rnum_in;
         cprod_ff <= cprod_in;
         dist_ff  <= dist_in;
         pprod_ff <= pprod_in;
         rx3_ff   <= rx;
         ry3_ff   <= ry;
      end
   end

   // stage b: row offset, column curve and pinch
   logic signed [13:0] rowoff;
   logic signed [20:0] ax_in;
   logic [8:0]         curve;
   logic [7:0]         pinch_in;
   logic [16:0]        tcc_in, bcc_in, pd_in;

   logic               m4_ff;
   logic signed [20:0] ax4_ff;
   logic signed [10:0] rx4_ff, ry4_ff;
   logic [16:0]        tcc_ff, bcc_ff, pd_ff;
   logic [7:0]         pinch4_ff;

   always_comb begin
      // truncate toward zero
      rowoff = 14'(rnum_ff >>> FRAC_BITS);
      if (rnum_ff[21] && (rnum_ff[7:0] != 8'd0))
         rowoff = rowoff + 14'sd1;
      ax_in    = 21'(signed'({rx3_ff, 8'b0})) - 21'(rowoff);
      curve    = 9'(10'(ONE) - 10'(cprod_ff >> 6));
      pinch_in = pprod_ff[15:8];
      tcc_in   = 17'(cfg.tc) * 17'(curve);
      bcc_in   = 17'(cfg.bc) * 17'(curve);
      pd_in    = 17'(pinch_in) * 17'(dist_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         m4_ff     <= m3_ff;
         ax4_ff    <= ax_in;
         rx4_ff    <= rx3_ff;
         ry4_ff    <= ry3_ff;
         tcc_ff    <= tcc_in;
         bcc_ff    <= bcc_in;
         pd_ff     <= pd_in;
         pinch4_ff <= pinch_in;
      end
   end

   // stage c: edge inset, column height, plain box test and its corner offsets
   logic [16:0]        left_in, right_in;
   logic [8:0]         hs0, hs;
   logic [17:0]        colh_in;
   logic               sok_in, sen_in;
   logic [9:0]         sdx_in, sdy_in;
   logic signed [11:0] r12, w12, h12, rx12, ry12, wr, hr, dxl, dxr, dyt, dyb;
   logic               cl, cr, ct, cb;

   logic               m5_ff, sok5_ff, sen5_ff;
   logic signed [20:0] ax5_ff;
   logic signed [10:0] ry5_ff;
   logic [16:0]        left5_ff, right5_ff;
   logic [17:0]        colh5_ff;
   logic [7:0]         pinch5_ff;
   logic [9:0]         sdx5_ff, sdy5_ff;

   always_comb begin
      left_in  = 17'((18'(tcc_ff[15:8]) * 18'(cfg.w)) >> 1);
      right_in = 17'((18'(bcc_ff[15:8]) * 18'(cfg.w)) >> 1);
      hs0      = 9'(10'(ONE) - 10'(pd_ff[15:8]));
      hs       = (hs0 < 9'(MIN_SCALE)) ? 9'(MIN_SCALE) : hs0;
      colh_in  = 18'(cfg.h) * 18'(hs);
      sok_in   = (ax4_ff >= 21'sd0) && (ax4_ff < signed'({3'b0, cfg.w, 8'b0}))
              && (ry4_ff >= 11'sd0) && (ry4_ff < signed'({1'b0, cfg.h}));
      r12  = signed'({3'b0, cfg.r});
      w12  = signed'({2'b0, cfg.w});
      h12  = signed'({2'b0, cfg.h});
      rx12 = 12'(rx4_ff);
      ry12 = 12'(ry4_ff);
      wr   = w12 - r12;
      hr   = h12 - r12;
      cl   = rx12 < r12;
      cr   = rx12 >= wr;
      ct   = ry12 < r12;
      cb   = ry12 >= hr;
      dxl  = r12 - rx12 - 12'sd1;
      dxr  = rx12 - wr;
      dyt  = r12 - ry12 - 12'sd1;
      dyb  = ry12 - hr;
      sen_in = 1'b1;
      if (cl && ct) begin
         sdx_in = dxl[9:0];
         sdy_in = dyt[9:0];
      end else if (cr && ct) begin
         sdx_in = dxr[9:0];
         sdy_in = dyt[9:0];
      end else if (cl && cb) begin
         sdx_in = dxl[9:0];
         sdy_in = dyb[9:0];
      end else if (cr && cb) begin
         sdx_in = dxr[9:0];
         sdy_in = dyb[9:0];
      end else begin
         sen_in = 1'b0;
         sdx_in = 10'd0;
         sdy_in = 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         m5_ff     <= m4_ff;
         ax5_ff    <= ax4_ff;
         ry5_ff    <= ry4_ff;
         left5_ff  <= left_in;
         right5_ff <= right_in;
         colh5_ff  <= colh_in;
         pinch5_ff <= pinch4_ff;
         sok5_ff   <= sok_in;
         sen5_ff   <= sen_in;
         sdx5_ff   <= sdx_in;
         sdy5_ff   <= sdy_in;
      end
   end

   // stage d: warped box bounds and corner radius
   logic [17:0]        top, effr;
   logic [18:0]        bot;
   logic signed [20:0] ay, lefts, effrs, tops, bots;
   logic [8:0]         omp;
   geom_type           g_in, g_ff;

   always_comb begin
      top   = 18'(({cfg.h, 8'b0} - colh5_ff) >> 1);
      bot   = 19'(top) + 19'(colh5_ff);
      effr  = {cfg.w, 8'b0} - 18'(right5_ff);
      ay    = 21'(signed'({ry5_ff, 8'b0}));
      lefts = signed'({4'b0, left5_ff});
      effrs = signed'({3'b0, effr});
      tops  = signed'({3'b0, top});
      bots  = signed'({2'b0, bot});
      omp   = 9'(ONE) - {1'b0, pinch5_ff};
      g_in.m   = m5_ff;
      g_in.sok = sok5_ff;
      g_in.sen = sen5_ff;
      g_in.sdx = sdx5_ff;
      g_in.sdy = sdy5_ff;
      g_in.wok = (ax5_ff >= lefts) && (ax5_ff < effrs) && (ay >= tops) && (ay < bots);
      g_in.wen = (cfg.r != 9'd0) && (pinch5_ff < 8'(ONE / 2));
      g_in.lx  = 19'(ax5_ff - lefts);
      g_in.ly  = 19'(ay - tops);
      g_in.aw  = effr - 18'(left5_ff);
      g_in.ah  = colh5_ff;
      g_in.er  = 17'(17'(cfg.r) * 17'(omp));
   end

   always_ff @(posedge clock) begin
      if (ld[3])
         g_ff <= g_in;
   end

   assign g_o = g_ff;

endmodule

FILE: rtl/core/rwpt_corner.sv
module rwpt_corner import rwpt_pkg::*; (
   input  logic     clock,
   input  logic [1:0] ld,
   input  cfg_type  cfg,
   input  geom_type g,
   output sq_type   sq_o
);

   logic signed [19:0] lxs, lys, ers, awe, ahe, dxl, dxr, dyt, dyb;
   logic               cl, cr, ct, cb, wen_in, en_in, ok_in;
   logic [16:0]        wdx, wdy, dx_in, dy_in, rr_in;

   logic               ok_ff, en_ff;
   logic [16:0]        dx_ff, dy_ff, rr_ff;
   sq_type             sq_in, sq_ff;

   // pick the corner a pixel falls in and its offsets from the arc centre
   always_comb begin
      lxs = signed'({1'b0, g.lx});
      lys = signed'({1'b0, g.ly});
      ers = signed'({3'b0, g.er});
      awe = signed'({2'b0, g.aw}) - ers;
      ahe = signed'({2'b0, g.ah}) - ers;
      cl  = lxs < ers;
      cr  = lxs >= awe;
      ct  = lys < ers;
      cb  = lys >= ahe;
      dxl = ers - lxs;
      dxr = lxs - awe;
      dyt = ers - lys;
      dyb = lys - ahe;
      wen_in = g.wen;
      if (cl && ct) begin
         wdx = dxl[16:0];
         wdy = dyt[16:0];
      end else if (cr && ct) begin
         wdx = dxr[16:0];
         wdy = dyt[16:0];
      end else if (cl && cb) begin
         wdx = dxl[16:0];
         wdy = dyb[16:0];
      end else if (cr && cb) begin
         wdx = dxr[16:0];
         wdy = dyb[16:0];
      end else begin
         wen_in = 1'b0;
         wdx    = 17'd0;
         wdy    = 17'd0;
      end
      if (cfg.simple) begin
         ok_in = g.m && g.sok;
         en_in = g.sen;
         dx_in = 17'(g.sdx);
         dy_in = 17'(g.sdy);
         rr_in = 17'(cfg.r);
      end else begin
         ok_in = g.m && g.wok;
         en_in = wen_in;
         dx_in = wdx;
         dy_in = wdy;
         rr_in = g.er;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         ok_ff <= ok_in;
         en_ff <= en_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         rr_ff <= rr_in;
      end
   end

   always_comb begin
      sq_in.ok  = ok_ff;
      sq_in.en  = en_ff;
      sq_in.dxx = 34'(dx_ff) * 34'(dx_ff);
      sq_in.dyy = 34'(dy_ff) * 34'(dy_ff);
      sq_in.rr2 = 34'(rr_ff) * 34'(rr_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[1])
         sq_ff <= sq_in;
   end

   assign sq_o = sq_ff;

endmodule

FILE: rtl/core/warped_rounded_rect_pixel_test_top.sv
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  req_tdata: pixel_x, pixel_y
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: inside_res, pixel_color
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// one pixel per cycle while the output is not stalled
// ten register stages: input, two divider stages, four geometry, two corner, output
// every stage has its own valid bit; a stage loads when it is empty or the next one loads,
// so bubbles close up behind a stalled output and nothing is lost or repeated
// reset clears the valid bits and the shape registers; csr_ready is always high
module warped_rounded_rect_pixel_test_top import rwpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_x [9:0], pixel_y [19:10], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // inside_res [0], pixel_color [16:1], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [9:0]  box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic [8:0]  corner_radius_ff;
   logic [31:0] warp_factors_ff;
   logic [16:0] corner_tilt_ff;
   logic [15:0] eye_color_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff         <= '0;
         box_y_ff         <= '0;
         box_w_ff         <= '0;
         box_h_ff         <= '0;
         corner_radius_ff <= '0;
         warp_factors_ff  <= '0;
         corner_tilt_ff   <= '0;
         eye_color_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BOX_X:         box_x_ff         <= csr_data[9:0];
            CSR_BOX_Y:         box_y_ff         <= csr_data[9:0];
            CSR_BOX_W:         box_w_ff         <= csr_data[9:0];
            CSR_BOX_H:         box_h_ff         <= csr_data[9:0];
            CSR_CORNER_RADIUS: corner_radius_ff <= csr_data[8:0];
            CSR_WARP_FACTORS:  warp_factors_ff  <= csr_data;
            CSR_CORNER_TILT:   corner_tilt_ff   <= csr_data[16:0];
            CSR_EYE_COLOR:     eye_color_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   cfg_type    cfg;
   logic [8:0] r1;

   always_comb begin
      r1 = (corner_radius_ff > box_w_ff[9:1]) ? box_w_ff[9:1] : corner_radius_ff;
      cfg.w  = box_w_ff;
      cfg.h  = box_h_ff;
      cfg.r  = (r1 > box_h_ff[9:1]) ? box_h_ff[9:1] : r1;
      cfg.tp = warp_factors_ff[7:0];
      cfg.bp = warp_factors_ff[15:8];
      cfg.tc = warp_factors_ff[23:16];
      cfg.bc = warp_factors_ff[31:24];
      // left eye swaps inner and outer
      if (corner_tilt_ff[16]) begin
         cfg.inner = tilt_q(corner_tilt_ff[15:8]);
         cfg.outer = tilt_q(corner_tilt_ff[7:0]);
      end else begin
         cfg.inner = tilt_q(corner_tilt_ff[7:0]);
         cfg.outer = tilt_q(corner_tilt_ff[15:8]);
      end
      cfg.simple = (warp_factors_ff == 32'd0);
   end

   // stage valid bits and load enables
   logic [NSTAGE-1:0] v_ff, v_in, ld;

   always_comb begin
      ld[NSTAGE-1] = !v_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--)
         ld[k] = !v_ff[k] || ld[k+1];
      v_in[0] = ld[0] ? req_tvalid : v_ff[0];
      for (int k = 1; k < NSTAGE; k++)
         v_in[k] = ld[k] ? v_ff[k-1] : v_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= '0;
      else
         v_ff <= v_in;
   end

   assign req_tready = ld[0];

   // input stage: position relative to the box
   logic signed [10:0] rx_ff, ry_ff;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         rx_ff <= signed'({1'b0, req_tdata[9:0]}) - signed'({1'b0, box_x_ff});
         ry_ff <= signed'({1'b0, req_tdata[19:10]}) - signed'({1'b0, box_y_ff});
      end
   end

   logic [8:0]         nx, ny;
   logic signed [10:0] rx2, ry2;

   rwpt_div u_div_x (
      .clock (clock),
      .ld    (ld[2:1]),
      .num_i (rx_ff),
      .den   (box_w_ff),
      .q_o   (nx),
      .num_o (rx2)
   );

   rwpt_div u_div_y (
      .clock (clock),
      .ld    (ld[2:1]),
      .num_i (ry_ff),
      .den   (box_h_ff),
      .q_o   (ny),
      .num_o (ry2)
   );

   geom_type g;

   rwpt_geom u_geom (
      .clock (clock),
      .ld    (ld[6:3]),
      .cfg   (cfg),
      .nx    (nx),
      .ny    (ny),
      .rx    (rx2),
      .ry    (ry2),
      .g_o   (g)
   );

   sq_type sq;

   rwpt_corner u_corner (
      .clock (clock),
      .ld    (ld[8:7]),
      .cfg   (cfg),
      .g     (g),
      .sq_o  (sq)
   );

   // output stage: circle compare
   logic        inside_in;
   logic [15:0] color_in;
   logic [34:0] dist2;
   logic        inside_ff;
   logic [15:0] color_ff;

   always_comb begin
      dist2     = 35'(sq.dxx) + 35'(sq.dyy);
      inside_in = sq.ok && !(sq.en && (dist2 > 35'(sq.rr2)));
      color_in  = inside_in ? eye_color_ff : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (ld[NSTAGE-1]) begin
         inside_ff <= inside_in;
         color_ff  <= color_in;
      end
   end

   assign rsp_tvalid = v_ff[NSTAGE-1];
   assign rsp_tdata  = {7'd0, color_ff, inside_ff};

endmodule

FILE: rtl/core/rwpt_checker.sv
module rwpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [3:0]  csr_index,
   input logic [31:0] csr_data
);

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");

   // an outside pixel carries no colour
   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[16:1] == 16'd0))
      else $error("colour on outside pixel");

   // a ready sink never holds up the input side
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled with ready sink");

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped or changed while stalled");

endmodule

bind warped_rounded_rect_pixel_test_top rwpt_checker u_rwpt_checker (.*);

FILE: tb/sv/warped_rounded_rect_pixel_test_top_tb.sv
`timescale 1ns / 100ps

module warped_rounded_rect_pixel_test_top_tb;
   import rwpt_pkg::*;

   localparam int LATENCY   = 12;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 700;

   typedef struct packed {
      logic [9:0] px;
      logic [9:0] py;
   } pixel_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] color;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // shadow copy of the shape registers
   logic [9:0]  sh_bx, sh_by, sh_bw, sh_bh;
   logic [8:0]  sh_r;
   logic [31:0] sh_warp;
   logic [16:0] sh_tilt;
   logic [15:0] sh_color;

   pixel_type   pixel_q[$];
   verdict_type verdict_q[$];
   int          n_fail = 0;
   int          n_mismatch = 0;
   int          n_checked = 0;
   int          n_inside = 0;
   int          n_cfg = 0;
   int          idle_cnt = 0;
   int          tx_gap = 0;
   int          rx_gap = 0;
   int          hold_cnt = 0;
   bit          jitter_on = 1'b1;
   bit          rx_hold_req = 1'b0;
   bit          tx_pause = 1'b0;
   bit          done = 1'b0;

   warped_rounded_rect_pixel_test_top u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint tilt_offset(input logic [7:0] b);
      longint v;
      v = longint'(b);
      if (v >= 128) v -= 256;
      return (v * 15 * ONE) / 128;
   endfunction

   function automatic bit corner_clear(input longint dx, input longint dy, input longint rr);
      return !(dx * dx + dy * dy > rr * rr);
   endfunction

   function automatic bit eye_covers(input longint rx, input longint ry);
      longint w, h, r, tp, bp, tc, bc, inner, outer, t, nx, ny, rowoff, ax;
      longint curve, left, right, cdist, pinch, hs, colh, top, bot, ay, eff;
      longint er, aw, ah, lx, ly;
      w = longint'(sh_bw); h = longint'(sh_bh); r = longint'(sh_r);
      tp = longint'(sh_warp[7:0]) * ONE / 256;
      bp = longint'(sh_warp[15:8]) * ONE / 256;
      tc = longint'(sh_warp[23:16]) * ONE / 256;
      bc = longint'(sh_warp[31:24]) * ONE / 256;
      inner = tilt_offset(sh_tilt[7:0]);
      outer = tilt_offset(sh_tilt[15:8]);
      if (r > w / 2) r = w / 2;
      if (r > h / 2) r = h / 2;
      if (sh_tilt[16]) begin
         t = inner; inner = outer; outer = t;
      end
      if (rx < -MARGIN || rx >= w + MARGIN || ry < -MARGIN || ry >= h + MARGIN) return 0;
      nx = 0; ny = 0;
      if (w > 0) begin
         nx = rx * ONE / w;
         if (nx < 0) nx = 0;
         if (nx > ONE) nx = ONE;
      end
      if (h > 0) begin
         ny = ry * ONE / h;
         if (ny < 0) ny = 0;
         if (ny > ONE) ny = ONE;
      end
      rowoff = (inner * (ONE - ny) + outer * ny) / ONE;
      ax = rx * ONE - rowoff;
      if (tp == 0 && bp == 0 && tc == 0 && bc == 0) begin
         if (!(ax >= 0 && ax < w * ONE && ry >= 0 && ry < h)) return 0;
         if (rx < r && ry < r) return corner_clear(r - rx - 1, r - ry - 1, r);
         if (rx >= w - r && ry < r) return corner_clear(rx - (w - r), r - ry - 1, r);
         if (rx < r && ry >= h - r) return corner_clear(r - rx - 1, ry - (h - r), r);
         if (rx >= w - r && ry >= h - r)
            return corner_clear(rx - (w - r), ry - (h - r), r);
         return 1;
      end
      curve = ONE - 4 * ny * (ONE - ny) / ONE;
      left  = (tc * curve / ONE) * w / 2;
      right = (bc * curve / ONE) * w / 2;
      cdist = (nx < ONE / 2 ? ONE / 2 - nx : nx - ONE / 2) * 2;
      pinch = (nx < ONE / 2) ? tp * (ONE - 2 * nx) / ONE : bp * (2 * nx - ONE) / ONE;
      hs = ONE - pinch * cdist / ONE;
      if (hs < MIN_SCALE) hs = MIN_SCALE;
      colh = h * hs;
      top = (h * ONE - colh) / 2;
      bot = top + colh;
      ay = ry * ONE;
      eff = w * ONE - right;
      if (!(ax >= left && ax < eff && ay >= top && ay < bot)) return 0;
      if (r > 0 && pinch < ONE / 2) begin
         er = r * (ONE - pinch);
         aw = eff - left; ah = bot - top;
         lx = ax - left; ly = ay - top;
         if (lx < er && ly < er) return corner_clear(er - lx, er - ly, er);
         if (lx >= aw - er && ly < er) return corner_clear(lx - (aw - er), er - ly, er);
         if (lx < er && ly >= ah - er) return corner_clear(er - lx, ly - (ah - er), er);
         if (lx >= aw - er && ly >= ah - er)
            return corner_clear(lx - (aw - er), ly - (ah - er), er);
      end
      return 1;
   endfunction

   function automatic verdict_type predict_pixel(input pixel_type p);
      verdict_type v;
      v.hit   = eye_covers(longint'(p.px) - longint'(sh_bx), longint'(p.py) - longint'(sh_by));
      v.color = v.hit ? sh_color : 16'h0;
      return v;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(predict_pixel(pixel_q.pop_front()));
         end
         if (!(req_tvalid && !req_tready)) begin
            // the pending head is driven only once the previous transaction has gone
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               req_tvalid <= 1'b0;
            end else if (tx_pause || pixel_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (jitter_on && $urandom_range(0, 19) == 0) begin
               tx_gap <= $urandom_range(0, 15);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= {4'h0, pixel_q[0].py, pixel_q[0].px};
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      verdict_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit   = rsp_tdata[0];
            got.color = rsp_tdata[16:1];
            n_checked++;
            if (got.hit) n_inside++;
            if (verdict_q.size() == 0) begin
               n_fail++;
               $display("unexpected transaction: %h", rsp_tdata);
            end else begin
               want = verdict_q.pop_front();
               if (got !== want || rsp_tdata[23:17] !== 7'h0) begin
                  n_fail++;
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("mismatch: expected inside %0d colour %h, got inside %0d colour %h",
                              want.hit, want.color, got.hit, got.color);
               end
            end
         end
         if (rx_hold_req && hold_cnt == 0) begin
            hold_cnt <= 300;
            rx_hold_req <= 1'b0;
            rsp_tready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_tready <= (hold_cnt == 1);
         end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            rsp_tready <= 1'b0;
         end else if (jitter_on && $urandom_range(0, 19) == 0) begin
            rx_gap <= $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset && !done) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_valid
             || hold_cnt > 0 || rx_hold_req)
            idle_cnt <= 0;
         else
            idle_cnt <= idle_cnt + 1;
         if (idle_cnt >= WDOG_MAX) begin
            $display("watchdog expired with %0d results outstanding", verdict_q.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BOX_X:         sh_bx    = value[9:0];
         CSR_BOX_Y:         sh_by    = value[9:0];
         CSR_BOX_W:         sh_bw    = value[9:0];
         CSR_BOX_H:         sh_bh    = value[9:0];
         CSR_CORNER_RADIUS: sh_r     = value[8:0];
         CSR_WARP_FACTORS:  sh_warp  = value;
         CSR_CORNER_TILT:   sh_tilt  = value[16:0];
         CSR_EYE_COLOR:     sh_color = value[15:0];
         default: ;
      endcase
      n_cfg++;
   endtask

   task automatic drain_pipe;
      while (pixel_q.size() > 0 || req_tvalid || verdict_q.size() > 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic load_shape(input logic [9:0] bx, by, bw, bh, input logic [8:0] r,
                             input logic [31:0] warp, input logic [16:0] tilt,
                             input logic [15:0] color);
      drain_pipe();
      write_reg(CSR_BOX_X, 32'(bx));
      write_reg(CSR_BOX_Y, 32'(by));
      write_reg(CSR_BOX_W, 32'(bw));
      write_reg(CSR_BOX_H, 32'(bh));
      write_reg(CSR_CORNER_RADIUS, 32'(r));
      write_reg(CSR_WARP_FACTORS, warp);
      write_reg(CSR_CORNER_TILT, 32'(tilt));
      write_reg(CSR_EYE_COLOR, 32'(color));
   endtask

   // mostly pixels in and around the box, some anywhere in the buffer
   task automatic queue_pixels(input int count);
      pixel_type p;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            p.px = 10'($urandom); p.py = 10'($urandom);
         end else begin
            p.px = 10'(int'(sh_bx) + $urandom_range(0, sh_bw + 44) - 22);
            p.py = 10'(int'(sh_by) + $urandom_range(0, sh_bh + 44) - 22);
         end
         pixel_q.push_back(p);
      end
   endtask

   initial begin
      pixel_type p;
      sh_bx = '0; sh_by = '0; sh_bw = '0; sh_bh = '0; sh_r = '0;
      sh_warp = '0; sh_tilt = '0; sh_color = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset shape, then a plain rounded box, then a warped left eye, then a zero-size box
      p.px = 10'd0;    p.py = 10'd0;    pixel_q.push_back(p);
      p.px = 10'd1023; p.py = 10'd1023; pixel_q.push_back(p);
      load_shape(10'd100, 10'd80, 10'd40, 10'd30, 9'd8, 32'h0, 17'h0, 16'hF81F);
      p.px = 10'd100; p.py = 10'd80;  pixel_q.push_back(p);   // rounded-off corner
      p.px = 10'd120; p.py = 10'd95;  pixel_q.push_back(p);
      p.px = 10'd139; p.py = 10'd109; pixel_q.push_back(p);
      p.px = 10'd140; p.py = 10'd95;  pixel_q.push_back(p);
      p.px = 10'd79;  p.py = 10'd95;  pixel_q.push_back(p);   // beyond the margin
      p.px = 10'd100; p.py = 10'd95;  pixel_q.push_back(p);
      load_shape(10'd0, 10'd0, 10'd1023, 10'd1023, 9'd511, 32'hFFFF_FFFF, 17'h1_807F,
                 16'hFFFF);
      p.px = 10'd511;  p.py = 10'd511;  pixel_q.push_back(p);
      p.px = 10'd0;    p.py = 10'd511;  pixel_q.push_back(p);
      p.px = 10'd1023; p.py = 10'd1023; pixel_q.push_back(p);
      p.px = 10'd700;  p.py = 10'd3;    pixel_q.push_back(p);
      load_shape(10'd1000, 10'd1000, 10'd0, 10'd0, 9'd0, 32'h0000_4000, 17'h0_7F80,
                 16'h1234);
      p.px = 10'd1000; p.py = 10'd1000; pixel_q.push_back(p);
      p.px = 10'd1010; p.py = 10'd990;  pixel_q.push_back(p);

      // random settings, each with a burst of pixels; small boxes keep hits dense
      for (int ph = 0; ph < 14; ph++) begin
         load_shape(10'($urandom), 10'($urandom),
                    (ph % 4 == 3) ? 10'($urandom) : 10'($urandom_range(0, 80)),
                    (ph % 4 == 3) ? 10'($urandom) : 10'($urandom_range(0, 80)),
                    9'($urandom),
                    (ph % 3 == 0) ? 32'h0 : 32'($urandom),
                    17'($urandom), 16'($urandom));
         if (ph == 12) jitter_on = 1'b0;
         if (ph == 4) rx_hold_req = 1'b1;
         queue_pixels(N_RANDOM / 14);
         if (ph == 7) begin
            // sender waits until every result is in
            tx_pause = 1'b1;
            while (verdict_q.size() > 0 || req_tvalid) @(posedge clock);
            tx_pause = 1'b0;
         end
      end
      drain_pipe();
      done = 1'b1;
      $display("covered %0d pixels, %0d inside, over %0d register writes",
               n_checked, n_inside, n_cfg);
      if (n_fail == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures", n_fail);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
